>>> design/rsks_pkg.sv
// Shared types, constants and the round update function of the key schedule.
`timescale 1ns / 1ps
`default_nettype none

package rsks_pkg;

    // Field widths of the key and round key beats.
    localparam int HALF_W = 64;
    localparam int KEY_W  = 2 * HALF_W;
    localparam int RND_W  = 5;

    // Default number of rounds after round 0.
    localparam int ROUND_COUNT_DEFAULT = 24;

    // Depth of the key queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Schedule constants.
    localparam int ROT_BITS = 13;
    localparam int RC_SHIFT = 59;

    typedef logic [HALF_W-1:0] half_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [RND_W-1:0]  round_t;

    localparam logic [3:0] SBOX [16] = '{
        4'he, 4'h4, 4'hb, 4'h1, 4'h7, 4'h9, 4'hc, 4'ha,
        4'hd, 4'h2, 4'h0, 4'hf, 4'h8, 4'h5, 4'h3, 4'h6
    };

    // One round: rotate left, substitute the two low nibbles, XOR in the round constant.
    function automatic key_t next_round_key(key_t cur, round_t rc);
        key_t rot;
        rot = {cur[KEY_W-1-ROT_BITS:0], cur[KEY_W-1:KEY_W-ROT_BITS]};
        rot[3:0] = SBOX[rot[3:0]];
        rot[7:4] = SBOX[rot[7:4]];
        rot[RC_SHIFT+RND_W-1:RC_SHIFT] = rot[RC_SHIFT+RND_W-1:RC_SHIFT] ^ rc;
        return rot;
    endfunction

endpackage

`default_nettype wire

>>> design/rsks_if.sv
// Handshake interfaces for the key channel and the round key channel.
`timescale 1ns / 1ps
`default_nettype none

interface rsks_key_if
    import rsks_pkg::*;
();
    logic  valid;
    logic  ready;
    half_t key_upper;
    half_t key_lower;

    modport source (output valid, output key_upper, output key_lower, input ready);
    modport sink   (input valid, input key_upper, input key_lower, output ready);
endinterface

interface rsks_round_key_if
    import rsks_pkg::*;
();
    logic   valid;
    logic   ready;
    round_t round_number;
    half_t  round_key_upper;
    half_t  round_key_lower;
    logic   final_round;

    modport source (
        output valid, output round_number, output round_key_upper,
        output round_key_lower, output final_round, input ready
    );
    modport sink (
        input valid, input round_number, input round_key_upper,
        input round_key_lower, input final_round, output ready
    );
endinterface

`default_nettype wire

>>> design/rsks_key_queue.sv
// Front end: accepts key beats into a short queue ahead of the round engine.
`timescale 1ns / 1ps
`default_nettype none

module rsks_key_queue
    import rsks_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rsks_key_if.sink    key_in,
    rsks_key_if.source  key_out
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    half_t             upper_mem [QUEUE_DEPTH];
    half_t             lower_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    // The queue takes a beat whenever it has a free entry.
    assign key_in.ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push           = key_in.valid && key_in.ready;
    assign pop            = key_out.valid && key_out.ready;

    assign key_out.valid     = (count_reg != '0);
    assign key_out.key_upper = upper_mem[rd_ptr_reg];
    assign key_out.key_lower = lower_mem[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            upper_mem[wr_ptr_reg] <= key_in.key_upper;
            lower_mem[wr_ptr_reg] <= key_in.key_lower;
        end
    end

endmodule

`default_nettype wire

>>> design/rsks_round_engine.sv
// Back end: steps the key register once per round key beat and holds it in an output register.
`timescale 1ns / 1ps
`default_nettype none

module rsks_round_engine
    import rsks_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rsks_key_if.sink         key_in,
    rsks_round_key_if.source round_key
);

    logic   valid_reg;
    logic   valid_next;
    round_t round_reg;
    round_t round_next;
    half_t  upper_reg;
    half_t  upper_next;
    half_t  lower_reg;
    half_t  lower_next;
    logic   final_reg;
    logic   final_next;
    logic   out_fire;
    logic   slot_free;
    logic   load;
    key_t   stepped;

    assign out_fire  = valid_reg && round_key.ready;
    // The output register is free for a new key when empty or when the last round leaves.
    assign slot_free = !valid_reg || (out_fire && final_reg);
    assign key_in.ready = slot_free;
    assign load      = slot_free && key_in.valid;

    // The round constant of the next round equals the current round number.
    assign stepped = next_round_key({upper_reg, lower_reg}, round_reg);

    always_comb
    begin
        valid_next = valid_reg;
        round_next = round_reg;
        upper_next = upper_reg;
        lower_next = lower_reg;
        final_next = final_reg;
        if (load)
        begin
            valid_next = 1'b1;
            round_next = '0;
            upper_next = key_in.key_upper;
            lower_next = key_in.key_lower;
            final_next = 1'b0;
        end
        else if (out_fire && final_reg)
        begin
            valid_next = 1'b0;
        end
        else if (out_fire)
        begin
            round_next = RND_W'(round_reg + 1'b1);
            upper_next = stepped[KEY_W-1:HALF_W];
            lower_next = stepped[HALF_W-1:0];
            final_next = (RND_W'(round_reg + 1'b1) == RND_W'(ROUND_COUNT));
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Round key payload.
    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        upper_reg <= upper_next;
        lower_reg <= lower_next;
        final_reg <= final_next;
    end

    assign round_key.valid           = valid_reg;
    assign round_key.round_number    = round_reg;
    assign round_key.round_key_upper = upper_reg;
    assign round_key.round_key_lower = lower_reg;
    assign round_key.final_round     = final_reg;

endmodule

`default_nettype wire

>>> design/rotate13_sbox_key_schedule.sv
// Top level of the rotate-13 S-box key schedule.
//
// Each 128-bit key beat yields ROUND_COUNT + 1 round key beats in round order, the first
// being the key itself and the last flagged by final_round. The back end emits one round key
// per cycle from its output register while the receiver is ready, using the single round
// update unit; a two-entry key queue in front takes new keys while a schedule is in
// progress, and when a key is queued the next schedule starts in the cycle after the last
// round key of the previous one leaves. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module rotate13_sbox_key_schedule
    import rsks_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rsks_key_if.sink         key,
    rsks_round_key_if.source round_key
);

    // Queued keys between the front and the back.
    rsks_key_if queued ();

    rsks_key_queue u_key_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key),
        .key_out (queued)
    );

    rsks_round_engine #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_round_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_in    (queued),
        .round_key (round_key)
    );

endmodule

`default_nettype wire

>>> test/rotate13_sbox_key_schedule_tb.sv
// Testbench for the rotate-13 S-box key schedule: directed and random keys against a scoreboard.
`timescale 1ns / 1ps

module rotate13_sbox_key_schedule_tb;
    import rsks_pkg::*;

    // Schedule shape as built with the default parameter.
    localparam int ROUNDS     = ROUND_COUNT_DEFAULT;
    localparam int ROT_AMOUNT = 13;
    localparam int RC_LSB     = 59;

    // Run length and pacing.
    localparam int DIRECTED_KEYS   = 14;
    localparam int RANDOM_KEYS     = 456;
    localparam int HOLD_OFF_AFTER  = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_LIMIT    = 10;

    // Slowest correct run: every round key waits out the longest stall and every key the
    // longest gap, plus the hold-off; the limit allows for that more than three times over.
    localparam int CYCLE_LIMIT = 2_500_000;

    // Keys that hit the edges: all zeros and ones, alternating bits, single bits at the ends
    // of each half, bits that the rotation carries across the halves, and a low byte for the
    // substitution.
    localparam half_t DIRECTED_UPPER [DIRECTED_KEYS] = '{
        64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
        64'h0000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
        64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'hfff8_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0123_4567_89ab_cdef, 64'h0000_0000_0000_0000
    };
    localparam half_t DIRECTED_LOWER [DIRECTED_KEYS] = '{
        64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000,
        64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000,
        64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 64'hfff8_0000_0000_0000,
        64'hfedc_ba98_7654_3210, 64'h0000_0000_0000_00ff
    };

    // One round key beat as seen on the output channel.
    typedef struct packed {
        round_t rnd;
        half_t  upper;
        half_t  lower;
        logic   is_final;
    } round_key_beat_t;

    // Expands each accepted key into its round keys and checks them in order.
    class key_schedule_scoreboard;
        round_key_beat_t expected_round_keys[$];
        int keys_noted;
        int round_keys_checked;
        int failures;

        function new();
            keys_noted         = 0;
            round_keys_checked = 0;
            failures           = 0;
        endfunction

        // The 4-bit substitution applied to the two low nibbles each round.
        function logic [3:0] sub_nibble(logic [3:0] n);
            case (n)
                4'h0: return 4'he;
                4'h1: return 4'h4;
                4'h2: return 4'hb;
                4'h3: return 4'h1;
                4'h4: return 4'h7;
                4'h5: return 4'h9;
                4'h6: return 4'hc;
                4'h7: return 4'ha;
                4'h8: return 4'hd;
                4'h9: return 4'h2;
                4'ha: return 4'h0;
                4'hb: return 4'hf;
                4'hc: return 4'h8;
                4'hd: return 4'h5;
                4'he: return 4'h3;
                default: return 4'h6;
            endcase
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("mismatch: %s", msg);
            end
        endfunction

        // Works out the whole schedule of an accepted key; round 0 is the key unchanged.
        function void note_key(half_t upper, half_t lower);
            key_t            reg_value;
            round_key_beat_t beat;
            reg_value = {upper, lower};
            for (int r = 0; r <= ROUNDS; r++)
            begin
                if (r > 0)
                begin
                    reg_value = {reg_value[KEY_W-1-ROT_AMOUNT:0],
                                 reg_value[KEY_W-1:KEY_W-ROT_AMOUNT]};
                    reg_value[3:0] = sub_nibble(reg_value[3:0]);
                    reg_value[7:4] = sub_nibble(reg_value[7:4]);
                    reg_value[RC_LSB+RND_W-1:RC_LSB] ^= round_t'(r - 1);
                end
                beat.rnd      = round_t'(r);
                beat.upper    = reg_value[KEY_W-1:HALF_W];
                beat.lower    = reg_value[HALF_W-1:0];
                beat.is_final = (r == ROUNDS);
                expected_round_keys.push_back(beat);
            end
            keys_noted++;
        endfunction

        // Compares a round key beat with the oldest expected one, field by field.
        function void check_round_key(round_key_beat_t got);
            round_key_beat_t want;
            string           bad_fields;
            if (expected_round_keys.size() == 0)
            begin
                report($sformatf("unexpected beat: round %0d upper %h lower %h final %b",
                                 got.rnd, got.upper, got.lower, got.is_final));
                return;
            end
            want = expected_round_keys.pop_front();
            round_keys_checked++;
            bad_fields = "";
            if (got.rnd !== want.rnd)
                bad_fields = {bad_fields, " round_number"};
            if (got.upper !== want.upper)
                bad_fields = {bad_fields, " round_key_upper"};
            if (got.lower !== want.lower)
                bad_fields = {bad_fields, " round_key_lower"};
            if (got.is_final !== want.is_final)
                bad_fields = {bad_fields, " final_round"};
            if (bad_fields != "")
            begin
                // The key of this beat is the oldest one with beats still pending.
                report($sformatf({"key %0d,%s differ: expected round %0d upper %h lower %h ",
                                  "final %b, got round %0d upper %h lower %h final %b"},
                                 keys_noted -
                                 (expected_round_keys.size() + ROUNDS + 1) / (ROUNDS + 1),
                                 bad_fields, want.rnd, want.upper, want.lower, want.is_final,
                                 got.rnd, got.upper, got.lower, got.is_final));
            end
        endfunction

        // Anything still waiting at the end never arrived.
        function void check_drained();
            if (expected_round_keys.size() != 0)
            begin
                report($sformatf("%0d round key beats never arrived",
                                 expected_round_keys.size()));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hold_off = 1'b0;
    int   keys_accepted = 0;
    int   cycle_count = 0;

    key_schedule_scoreboard sb;
    round_key_beat_t        seen_beat;

    rsks_key_if       key_ch ();
    rsks_round_key_if round_key_ch ();

    rotate13_sbox_key_schedule dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_ch),
        .round_key (round_key_ch)
    );

    always #2 clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(3, 1);
        if (pick < 96)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Random key half: dense, sparse, one bit set or one bit clear.
    function automatic half_t random_half();
        half_t dense;
        dense = {$urandom, $urandom};
        case ($urandom_range(5))
            3: return dense & {$urandom, $urandom} & {$urandom, $urandom};
            4: return half_t'(1) << $urandom_range(63);
            5: return ~(half_t'(1) << $urandom_range(63));
            default: return dense;
        endcase
    endfunction

    // Offers one key from a falling edge and returns at the falling edge after acceptance.
    task automatic send_key(half_t upper, half_t lower);
        key_ch.valid     <= 1'b1;
        key_ch.key_upper <= upper;
        key_ch.key_lower <= lower;
        do
            @(posedge clk);
        while (!key_ch.ready);
        sb.note_key(upper, lower);
        keys_accepted++;
        @(negedge clk);
    endtask

    // Drops valid for a number of cycles; no change at all for a zero gap.
    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            key_ch.valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Cycle count and timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d keys accepted", cycle_count,
                     keys_accepted);
            $display("status: fail");
            $finish;
        end
    end

    // Every accepted round key beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && round_key_ch.valid && round_key_ch.ready)
        begin
            seen_beat.rnd      = round_key_ch.round_number;
            seen_beat.upper    = round_key_ch.round_key_upper;
            seen_beat.lower    = round_key_ch.round_key_lower;
            seen_beat.is_final = round_key_ch.final_round;
            sb.check_round_key(seen_beat);
        end
    end

    // Receiver: runs of ready with random stalls, now and then a long run without any.
    initial
    begin : round_key_receiver
        int run_len;
        int stall_len;
        round_key_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(400, 150) : $urandom_range(40, 1);
            repeat (run_len)
            begin
                @(negedge clk);
                round_key_ch.ready <= !hold_off;
            end
            stall_len = idle_length();
            repeat (stall_len)
            begin
                @(negedge clk);
                round_key_ch.ready <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here, so that the key queue fills and stalls the input.
    initial
    begin : receiver_hold_off
        wait (keys_accepted >= HOLD_OFF_AFTER);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Reset, stimulus and end of run.
    initial
    begin : key_sender
        int burst_left;
        int gap;
        sb = new();
        key_ch.valid     = 1'b0;
        key_ch.key_upper = '0;
        key_ch.key_lower = '0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed keys.
        for (int i = 0; i < DIRECTED_KEYS; i++)
        begin
            idle_sender(idle_length());
            send_key(DIRECTED_UPPER[i], DIRECTED_LOWER[i]);
        end

        // Random keys, with bursts of back-to-back beats and none while the receiver holds off.
        for (int i = 0; i < RANDOM_KEYS; i++)
        begin
            if (burst_left == 0 && $urandom_range(19) == 0)
                burst_left = $urandom_range(30, 5);
            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                gap = hold_off ? 0 : idle_length();
            end
            idle_sender(gap);
            send_key(random_half(), random_half());
        end
        key_ch.valid <= 1'b0;

        // Let the last schedules drain, then allow for any stray beats.
        while (sb.expected_round_keys.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();

        $display("covered %0d keys (%0d directed, %0d random) and %0d round key beats,",
                 sb.keys_noted, DIRECTED_KEYS, sb.keys_noted - DIRECTED_KEYS,
                 sb.round_keys_checked);
        $display("with random gaps on both sides and a %0d-cycle receiver hold-off; %0d mismatches",
                 HOLD_OFF_CYCLES, sb.failures);
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
design/rsks_pkg.sv
design/rsks_if.sv
design/rsks_key_queue.sv
design/rsks_round_engine.sv
design/rotate13_sbox_key_schedule.sv
test/rotate13_sbox_key_schedule_tb.sv
